// File: src/ppsv_pkg.sv
// ---------------------------------------------------------------------------
// ppsv_pkg: shared types and constants for the paged package stream validator
// Item formats, error codes, header layout and the per-byte CRC-32 step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ppsv_pkg;

  localparam int unsigned PAGES        = 4;
  localparam int unsigned HEADER_BYTES = 64;
  localparam int unsigned SIZE_BITS    = 20;
  localparam int unsigned CFG_BITS     = 20;
  localparam int unsigned PREFIX_BYTES = 10;

  localparam logic [31:0] CRC_POLY     = 32'hedb88320;
  localparam logic [31:0] CRC_INIT     = 32'hffffffff;
  localparam logic [7:0]  TRAILER      = 8'h3b;
  localparam logic [31:0] MIN_PAGE     = 32'd13;
  localparam logic [31:0] HDR_SIZE     = 32'h40;

  // header word indexes (byte offset / 4)
  localparam int unsigned W_MAGIC   = 0;
  localparam int unsigned W_VERSION = 1;
  localparam int unsigned W_GEN     = 2;
  localparam int unsigned W_TOTAL   = 3;
  localparam int unsigned W_PCOUNT  = 6;
  localparam int unsigned W_ZERO    = 7;
  localparam int unsigned W_LEN     = 8;
  localparam int unsigned W_CRC     = 8 + PAGES;

  localparam logic [31:0] MAGIC   = 32'h47415041;
  localparam logic [31:0] VERSION = 32'h00400002;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_FORMAT  = 3'd1,
    ERR_RANGE   = 3'd2,
    ERR_SUM     = 3'd3,
    ERR_PAGE    = 3'd4,
    ERR_OVERRUN = 3'd5
  } err_t;

  typedef enum logic {
    REG_MAX_PACKAGE = 1'b0,
    REG_MAX_PAGE    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic        in_body;
    logic [1:0]  page_number;
    logic [7:0]  byte_out;
    logic        page_end;
    logic        package_complete;
    logic [30:0] package_generation;
  } out_item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0: r = 8'h47;
      4'd1: r = 8'h49;
      4'd2: r = 8'h46;
      4'd3: r = 8'h38;
      4'd4: r = 8'h39;
      4'd5: r = 8'h61;
      4'd6: r = 8'h40;
      4'd7: r = 8'h01;
      4'd8: r = 8'hf0;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/ppsv_if.sv
// ---------------------------------------------------------------------------
// ppsv_if: valid/ready channels for the validator
// Input channel carries op and byte; output channel carries the result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface ppsv_in_if;
  logic               valid;
  logic               ready;
  ppsv_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface ppsv_out_if;
  logic                valid;
  logic                ready;
  ppsv_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

// File: src/paged_package_stream_validator.sv
// ---------------------------------------------------------------------------
// paged_package_stream_validator: checks a paged package one byte at a time
// Header collection and range checks, per-page CRC-32, prefix and trailer.
// ---------------------------------------------------------------------------
// usage:
//   in_ch  : one word per byte, op = start clears all state, op = data feeds
//            the next package byte
//   out_ch : one result word per input word, in order
//   cfg    : cfg_we/cfg_index/cfg_data set the size limits, write while idle
// a word taken on in_ch has its result registered and shown on out_ch in the following cycle.
// throughput is one word per cycle while out_ch does not stall; the header
// check (length sum over four pages) and the eight-step CRC byte update are
// both combinational between the input handshake and the result register.
// in_ch.ready is high whenever the result register is empty or being taken,
// so a stall on out_ch holds one result and stops input until it drains.
// reset clears the validator state, drops any pending result and restores
// the default limits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module paged_package_stream_validator (
  input  wire                            clk,
  input  wire                            rst,
  ppsv_in_if.sink                        in_ch,
  ppsv_out_if.source                     out_ch,
  input  wire                            cfg_we,
  input  wire                            cfg_index,
  input  wire [ppsv_pkg::CFG_BITS-1:0]   cfg_data
);
  import ppsv_pkg::*;

  logic [CFG_BITS-1:0]  max_package_bytes;
  logic [CFG_BITS-1:0]  max_page_bytes;
  logic [7:0]           hdr [HEADER_BYTES];
  logic [31:0]          hdr_word [HEADER_BYTES/4];

  logic [6:0]           header_count, header_count_next;
  logic [30:0]          generation, generation_next;
  logic [2:0]           current_page, current_page_next;
  logic [SIZE_BITS-1:0] page_bytes_seen, page_bytes_seen_next;
  logic [31:0]          crc, crc_next;
  logic [3:0]           prefix_count, prefix_count_next;
  logic                 prefix_ok, prefix_ok_next;
  logic                 done, done_next;
  logic [2:0]           sticky, sticky_next;

  logic                 out_valid;
  out_item_t            out_item, res;
  logic                 take, hdr_we;
  logic [2:0]           hdr_err;
  logic [31:0]          page_len, crc_expected;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign take         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_item;

  for (genvar w = 0; w < HEADER_BYTES/4; w++) begin : g_word
    assign hdr_word[w] = {hdr[4*w+3], hdr[4*w+2], hdr[4*w+1], hdr[4*w]};
  end

  assign page_len     = hdr_word[4'(W_LEN) + 4'(current_page[1:0])];
  assign crc_expected = hdr_word[4'(W_CRC) + 4'(current_page[1:0])];

  // header check from the stored bytes, all of which precede the last one
  always_comb begin
    logic [33:0] sum;
    logic        bad;
    sum = '0;
    bad = 1'b0;
    if (hdr_word[W_MAGIC] != MAGIC || hdr_word[W_VERSION] != VERSION ||
        hdr_word[W_PCOUNT] != 32'(PAGES) || hdr_word[W_ZERO] != 32'd0) begin
      hdr_err = ERR_FORMAT;
    end else if (hdr_word[W_GEN] == 32'd0 || hdr_word[W_GEN][31] ||
                 hdr_word[W_TOTAL] < HDR_SIZE ||
                 hdr_word[W_TOTAL] > 32'(max_package_bytes)) begin
      hdr_err = ERR_RANGE;
    end else begin
      for (int p = 0; p < PAGES; p++) begin
        if (hdr_word[W_LEN+p] < MIN_PAGE || hdr_word[W_LEN+p] > 32'(max_page_bytes) ||
            sum + 34'(hdr_word[W_LEN+p]) > 34'(max_package_bytes)) begin
          bad = 1'b1;
        end
        sum = sum + 34'(hdr_word[W_LEN+p]);
      end
      if (bad) begin
        hdr_err = ERR_RANGE;
      end else if (sum != 34'(hdr_word[W_TOTAL] - HDR_SIZE)) begin
        hdr_err = ERR_SUM;
      end else begin
        hdr_err = ERR_NONE;
      end
    end
  end

  always_comb begin
    logic [7:0] b;
    b                    = in_ch.item.data_byte;
    header_count_next    = header_count;
    generation_next      = generation;
    current_page_next    = current_page;
    page_bytes_seen_next = page_bytes_seen;
    crc_next             = crc;
    prefix_count_next    = prefix_count;
    prefix_ok_next       = prefix_ok;
    done_next            = done;
    sticky_next          = sticky;
    hdr_we               = 1'b0;
    res                  = '0;
    res.byte_out         = b;
    if (take) begin
      if (in_ch.item.op == OP_START) begin
        header_count_next    = '0;
        generation_next      = '0;
        current_page_next    = '0;
        page_bytes_seen_next = '0;
        crc_next             = CRC_INIT;
        prefix_count_next    = '0;
        prefix_ok_next       = 1'b1;
        done_next            = 1'b0;
        sticky_next          = ERR_NONE;
        res.byte_out         = '0;
      end else if (sticky != ERR_NONE) begin
        res.error_code = sticky;
      end else if (done) begin
        sticky_next    = ERR_OVERRUN;
        res.error_code = ERR_OVERRUN;
      end else if (header_count < 7'(HEADER_BYTES)) begin
        hdr_we            = 1'b1;
        header_count_next = header_count + 7'd1;
        if (header_count == 7'(HEADER_BYTES - 1)) begin
          res.error_code = hdr_err;
          sticky_next    = hdr_err;
          if (hdr_err == ERR_NONE) begin
            generation_next = hdr_word[W_GEN][30:0];
          end
        end
      end else begin
        res.in_body     = 1'b1;
        res.page_number = current_page[1:0];
        crc_next        = crc_byte(crc, b);
        if (prefix_count < 4'(PREFIX_BYTES)) begin
          prefix_ok_next    = prefix_ok && (b == prefix_byte(prefix_count));
          prefix_count_next = prefix_count + 4'd1;
        end
        page_bytes_seen_next = page_bytes_seen + SIZE_BITS'(1);
        if (32'(page_bytes_seen_next) == page_len) begin
          if (prefix_count_next == 4'(PREFIX_BYTES) && prefix_ok_next &&
              b == TRAILER && ~crc_next == crc_expected) begin
            res.page_end         = 1'b1;
            current_page_next    = current_page + 3'd1;
            page_bytes_seen_next = '0;
            crc_next             = CRC_INIT;
            prefix_count_next    = '0;
            prefix_ok_next       = 1'b1;
            if (current_page_next == 3'(PAGES)) begin
              done_next = 1'b1;
            end
          end else begin
            res.error_code = ERR_PAGE;
            sticky_next    = ERR_PAGE;
          end
        end
      end
    end
    res.package_complete   = done_next;
    res.package_generation = generation_next;
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr[header_count[5:0]] <= in_ch.item.data_byte;
    end
    if (take) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_package_bytes <= CFG_BITS'(393216);
      max_page_bytes    <= CFG_BITS'(98304);
      header_count      <= '0;
      generation        <= '0;
      current_page      <= '0;
      page_bytes_seen   <= '0;
      crc               <= CRC_INIT;
      prefix_count      <= '0;
      prefix_ok         <= 1'b1;
      done              <= 1'b0;
      sticky            <= ERR_NONE;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_PACKAGE) begin
          max_package_bytes <= cfg_data;
        end else begin
          max_page_bytes <= cfg_data;
        end
      end
      header_count    <= header_count_next;
      generation      <= generation_next;
      current_page    <= current_page_next;
      page_bytes_seen <= page_bytes_seen_next;
      crc             <= crc_next;
      prefix_count    <= prefix_count_next;
      prefix_ok       <= prefix_ok_next;
      done            <= done_next;
      sticky          <= sticky_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_err: assert property (@(posedge clk) disable iff (rst)
    done |-> (sticky == ERR_NONE || sticky == ERR_OVERRUN))
    else $error("done with unexpected error code");
  a_page_range: assert property (@(posedge clk) disable iff (rst)
    current_page <= 3'(PAGES))
    else $error("page index past last page");
  a_end_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.page_end |-> out_item.in_body && out_item.error_code == ERR_NONE)
    else $error("page end outside body");
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    take && in_ch.item.op == OP_START |=> header_count == 7'd0 && generation == 31'd0)
    else $error("start did not clear state");
  a_body_after_hdr: assert property (@(posedge clk) disable iff (rst)
    current_page != 3'd0 |-> header_count == 7'(HEADER_BYTES))
    else $error("body progress before header complete");
`endif

endmodule
`default_nettype wire
